// ===== hdl/dso_pkg.sv =====
// Shared types, constants and Q16.16 helpers for the dendritic step unit.
// Used by every module of the block; depends on nothing.

package dso_pkg;

    localparam int NODE_W     = 10;
    localparam int Q_W        = 32;
    localparam int IN_DATA_W  = 112;  // 106 payload bits, padded to whole bytes
    localparam int OUT_DATA_W = 80;   // 74 payload bits, padded to whole bytes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_STAGES = 15;   // arithmetic stages after the density store

    typedef enum logic {
        KIND_STEP = 1'b0,
        KIND_LOAD = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_ALPHA       = 3'd0,
        REG_RATE_BETA        = 3'd1,
        REG_DECAY_ALPHA      = 3'd2,
        REG_DECAY_BETA       = 3'd3,
        REG_INVERSE_STEP     = 3'd4,
        REG_INVERSE_RATE_GAP = 3'd5,
        REG_RATE_SUM_FACTOR  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic        [30:0] rate_alpha;
        logic        [30:0] rate_beta;
        logic        [16:0] decay_alpha;
        logic        [16:0] decay_beta;
        logic        [30:0] inverse_step;
        logic signed [31:0] inverse_rate_gap;
        logic        [30:0] rate_sum_factor;
    } cfg_t;

    // One pipeline slot; each stage fills in the terms it computes.
    typedef struct packed {
        logic               valid;
        logic               ok;      // node inside the density store
        logic [NODE_W-1:0]  node;
        logic signed [31:0] p;
        logic signed [31:0] v;
        logic signed [31:0] dv;
        logic signed [31:0] q;
        logic signed [31:0] d;
        logic signed [31:0] g;
        logic signed [31:0] f;
        logic signed [31:0] a;
        logic signed [31:0] t;
        logic signed [31:0] c1;
        logic signed [31:0] s;
        logic signed [31:0] e1;
        logic signed [31:0] e2;
        logic signed [31:0] vn;
        logic signed [31:0] dvn;
        logic signed [47:0] r1;
        logic signed [63:0] prod;
        logic signed [63:0] prod2;
    } pipe_t;

    localparam cfg_t CFG_RESET = '{
        rate_alpha:       31'd65536,
        rate_beta:        31'd65536,
        decay_alpha:      17'd65536,
        decay_beta:       17'd65536,
        inverse_step:     31'd65536,
        inverse_rate_gap: 32'sd65536,
        rate_sum_factor:  31'd131072
    };

    function automatic logic signed [63:0] sx32(input logic signed [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic signed [63:0] sx48(input logic signed [47:0] x);
        return {{16{x[47]}}, x};
    endfunction

    function automatic logic signed [31:0] u31(input logic [30:0] x);
        return $signed({1'b0, x});
    endfunction

    function automatic logic signed [31:0] u17(input logic [16:0] x);
        return $signed({15'd0, x});
    endfunction

    function automatic logic signed [63:0] qprod(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] r;
        r = sx32(a) * sx32(b);
        return r;
    endfunction

    // Drop 16 fraction bits, halves toward plus infinity.
    function automatic logic signed [47:0] qround(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = x + 64'sd32768;
        return r[63:16];
    endfunction

    function automatic logic signed [31:0] satq(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] satround(input logic signed [63:0] x);
        return satq(sx48(qround(x)));
    endfunction

endpackage

// ===== hdl/dendritic_second_order_step_unit.sv =====
// Top level of the dendritic second-order step unit: ports, configuration
// registers, stall control. Depends on dso_pkg, dso_density_store, dso_arith_pipe.
//
// Takes one item per clock while no output beat waits. The accepting edge of a
// step loads the density read register; fifteen arithmetic stages follow, and
// the last of them drives m_tvalid. The stage count is set by the longest
// dependent path: the density difference, six Q16.16 products in a row (each
// a multiply stage and a rounding stage) and two sums, one between the products
// and one after the last. Load items (tuser high) update the stored density and
// produce no output. The density memory is a single read-first port, so a step
// on a node may directly follow a load or step on the same node. The pipeline
// moves as one; it holds only while the output beat waits, and s_tready follows
// that. The stored density of a node is undefined until a load or step has
// written it. Configuration registers may only be written while the pipeline
// is empty.

module dendritic_second_order_step_unit #(
    parameter int NODES = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input: tdata = node, pulse_density, potential, potential_rate (low to high)
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dso_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,   // kind: 0 step, 1 load
    // output: tdata = node_out, new_potential, new_potential_rate (low to high)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dso_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [dso_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dso_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dso_pkg::*;

    cfg_t   cfg_reg;
    pipe_t  front;
    pipe_t  result;
    logic   adv;

    assign adv      = !result.valid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_RATE_ALPHA:       cfg_reg.rate_alpha       <= cfg_data[30:0];
                REG_RATE_BETA:        cfg_reg.rate_beta        <= cfg_data[30:0];
                REG_DECAY_ALPHA:      cfg_reg.decay_alpha      <= cfg_data[16:0];
                REG_DECAY_BETA:       cfg_reg.decay_beta       <= cfg_data[16:0];
                REG_INVERSE_STEP:     cfg_reg.inverse_step     <= cfg_data[30:0];
                REG_INVERSE_RATE_GAP: cfg_reg.inverse_rate_gap <= $signed(cfg_data);
                REG_RATE_SUM_FACTOR:  cfg_reg.rate_sum_factor  <= cfg_data[30:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    dso_density_store #(
        .NODES(NODES)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_kind  (kind_t'(s_tuser)),
        .in_node  (s_tdata[9:0]),
        .in_p     ($signed(s_tdata[41:10])),
        .in_v     ($signed(s_tdata[73:42])),
        .in_dv    ($signed(s_tdata[105:74])),
        .stage_o  (front)
    );

    dso_arith_pipe u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cfg     (cfg_reg),
        .st_in   (front),
        .st_out  (result)
    );

    assign m_tvalid = result.valid;
    assign m_tdata  = {6'd0, result.dvn, result.vn, result.node};

endmodule

// ===== hdl/dso_density_store.sv =====
// Entry stage: per-node previous pulse density memory plus the input register.
// Depends on dso_pkg.

module dso_density_store #(
    parameter int NODES = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  dso_pkg::kind_t              in_kind,
    input  logic [dso_pkg::NODE_W-1:0]  in_node,
    input  logic signed [31:0]          in_p,
    input  logic signed [31:0]          in_v,
    input  logic signed [31:0]          in_dv,
    output dso_pkg::pipe_t              stage_o
);
    import dso_pkg::*;

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

    logic signed [31:0] mem [NODES];
    logic signed [31:0] q_reg;
    pipe_t              front_reg;
    pipe_t              front_next;
    logic [AW-1:0]      addr;
    logic               node_ok;

    assign addr    = AW'(in_node);
    assign node_ok = ({{(32-NODE_W){1'b0}}, in_node} < 32'(NODES));

    always_comb begin
        front_next       = '0;
        front_next.valid = in_valid && (in_kind == KIND_STEP);
        front_next.ok    = node_ok;
        front_next.node  = in_node;
        front_next.p     = in_p;
        front_next.v     = in_v;
        front_next.dv    = in_dv;
    end

    // Read-first: the read sees the density left by the previous transfer,
    // and the new density goes in at the same edge, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (adv) begin
            q_reg <= mem[addr];
            if (in_valid && node_ok) begin
                mem[addr] <= in_p;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (adv) begin
            front_reg <= front_next;
        end
    end

    always_comb begin
        stage_o   = front_reg;
        stage_o.q = q_reg;
    end

endmodule

// ===== hdl/dso_arith_pipe.sv =====
// Arithmetic pipeline of the step: products, roundings and saturating sums, with independent terms sharing a stage.
// Depends on dso_pkg; fed by dso_density_store.

module dso_arith_pipe (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  dso_pkg::cfg_t  cfg,
    input  dso_pkg::pipe_t st_in,
    output dso_pkg::pipe_t st_out
);
    import dso_pkg::*;

    pipe_t st_reg  [1:NUM_STAGES];
    pipe_t st_next [1:NUM_STAGES];

    always_comb begin
        st_next[1] = st_in;
        for (int k = 2; k <= NUM_STAGES; k++) begin
            st_next[k] = st_reg[k-1];
        end

        // out-of-range node reads density zero
        st_next[1].q = st_in.ok ? st_in.q : '0;
        st_next[1].d = satq(sx32(st_in.p) - sx32(st_next[1].q));

        st_next[2].prod = qprod(st_reg[1].d, u31(cfg.inverse_step));
        st_next[3].g    = satround(st_reg[2].prod);
        st_next[4].prod = qprod(u31(cfg.rate_sum_factor), st_reg[3].g);
        st_next[5].f    = satround(st_reg[4].prod);
        st_next[6].a    = satq(sx32(st_reg[5].q) - sx32(st_reg[5].f) - sx32(st_reg[5].v));
        st_next[7].prod = qprod(st_reg[6].a, u31(cfg.rate_beta));
        st_next[8].t    = satq(sx48(qround(st_reg[7].prod)) - sx32(st_reg[7].dv)
                               + sx32(st_reg[7].g));
        st_next[9].prod = qprod(st_reg[8].t, cfg.inverse_rate_gap);
        st_next[10].c1  = satround(st_reg[9].prod);

        st_next[11].prod = qprod(st_reg[10].c1, u17(cfg.decay_alpha));
        st_next[11].s    = satq(-sx32(st_reg[10].c1) - sx32(st_reg[10].a));

        st_next[12].e1    = satround(st_reg[11].prod);
        st_next[12].prod2 = qprod(u17(cfg.decay_beta), st_reg[11].s);

        st_next[13].e2   = satround(st_reg[12].prod2);
        st_next[13].prod = qprod(st_reg[12].e1, u31(cfg.rate_alpha));

        st_next[14].r1    = qround(st_reg[13].prod);
        st_next[14].prod2 = qprod(st_reg[13].e2, u31(cfg.rate_beta));
        st_next[14].vn    = satq(sx32(st_reg[13].e1) + sx32(st_reg[13].e2)
                                 + sx32(st_reg[13].p) - sx32(st_reg[13].f));

        st_next[15].dvn = satq(-sx48(st_reg[14].r1) - sx48(qround(st_reg[14].prod2))
                               + sx32(st_reg[14].g));
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= NUM_STAGES; k++) begin
            if (!aresetn) begin
                st_reg[k].valid <= 1'b0;
            end else if (adv) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign st_out = st_reg[NUM_STAGES];

endmodule

// ===== hdl/dso_checker.sv =====
// Port-level checks for the dendritic step unit, bound onto the top level.
// Depends on dso_pkg and dendritic_second_order_step_unit.

module dso_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [dso_pkg::IN_DATA_W-1:0]     s_tdata,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [dso_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                              cfg_we,
    input logic [dso_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [dso_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dso_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // input side stalls only behind a waiting output beat
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output side is free");

    // a waiting output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat changed while stalled");

    // byte padding of the result stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:74] == '0))
        else $error("nonzero padding in result");

endmodule

bind dendritic_second_order_step_unit dso_checker u_dso_checker (.*);

// ===== test/dso_step_checker.sv =====
// Scoreboard for the dendritic step unit: mirrors the config registers and the
// per-node density store, predicts each step result and checks it in order.
// Depends on dso_pkg for widths and the register index names.
`timescale 1ns / 1ps

module dso_step_checker #(
    parameter int NODES = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dso_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dso_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [dso_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dso_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              results_pending
);
    import dso_pkg::*;

    localparam longint Q_TOP    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_BOTTOM = -64'sh0000_0000_8000_0000;

    typedef struct {
        logic [NODE_W-1:0]  node;
        logic signed [31:0] potential;
        logic signed [31:0] rate;
    } step_result_t;

    // mirrored register file
    logic [30:0]        rate_a, rate_b, inv_dt, inv_sum;
    logic [16:0]        fade_a, fade_b;
    logic signed [31:0] inv_gap;

    logic signed [31:0] density_mem [NODES];
    step_result_t       awaited_steps [$];
    int                 bad;

    function automatic longint clamp_q(longint x);
        if (x > Q_TOP) return Q_TOP;
        if (x < Q_BOTTOM) return Q_BOTTOM;
        return x;
    endfunction

    // Q16.16 product, rounded to nearest with halves toward plus infinity
    function automatic longint fixmul(longint x, longint y);
        longint prod;
        prod = x * y + 64'sd32768;
        return prod >>> 16;
    endfunction

    function automatic step_result_t predict_step(logic [NODE_W-1:0] node,
                                                  logic signed [31:0] p32,
                                                  logic signed [31:0] v32,
                                                  logic signed [31:0] dv32,
                                                  logic signed [31:0] prev);
        longint p, v, dv, q, g, f, a, c1, e1, e2;
        step_result_t r;
        p  = longint'(p32);
        v  = longint'(v32);
        dv = longint'(dv32);
        q  = longint'(prev);
        g  = clamp_q(fixmul(clamp_q(p - q), longint'(inv_dt)));
        f  = clamp_q(fixmul(longint'(inv_sum), g));
        a  = clamp_q(q - f - v);
        c1 = clamp_q(fixmul(clamp_q(fixmul(a, longint'(rate_b)) - dv + g),
                            longint'(inv_gap)));
        e1 = clamp_q(fixmul(c1, longint'(fade_a)));
        e2 = clamp_q(fixmul(longint'(fade_b), clamp_q(-c1 - a)));
        r.node      = node;
        r.potential = 32'(clamp_q(e1 + e2 + p - f));
        r.rate      = 32'(clamp_q(-fixmul(e1, longint'(rate_a))
                                  - fixmul(e2, longint'(rate_b)) + g));
        return r;
    endfunction

    always @(posedge aclk) begin
        logic [NODE_W-1:0]  in_node, got_node;
        logic signed [31:0] in_p, in_v, in_dv, got_v, got_dv, prev;
        step_result_t       want;
        if (!aresetn) begin
            rate_a  <= 31'd65536;
            rate_b  <= 31'd65536;
            fade_a  <= 17'd65536;
            fade_b  <= 17'd65536;
            inv_dt  <= 31'd65536;
            inv_gap <= 32'sd65536;
            inv_sum <= 31'd131072;
            awaited_steps.delete();
        end else begin
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_RATE_ALPHA:       rate_a  <= cfg_data[30:0];
                    REG_RATE_BETA:        rate_b  <= cfg_data[30:0];
                    REG_DECAY_ALPHA:      fade_a  <= cfg_data[16:0];
                    REG_DECAY_BETA:       fade_b  <= cfg_data[16:0];
                    REG_INVERSE_STEP:     inv_dt  <= cfg_data[30:0];
                    REG_INVERSE_RATE_GAP: inv_gap <= cfg_data;
                    REG_RATE_SUM_FACTOR:  inv_sum <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got_node = m_tdata[0 +: NODE_W];
                got_v    = m_tdata[NODE_W +: Q_W];
                got_dv   = m_tdata[NODE_W + Q_W +: Q_W];
                if (awaited_steps.size() == 0) begin
                    $error("unexpected result transfer for node %0d", got_node);
                    bad++;
                end else begin
                    want = awaited_steps.pop_front();
                    if (got_node !== want.node) begin
                        $error("node_out: expected %0d, got %0d", want.node, got_node);
                        bad++;
                    end
                    if (got_v !== want.potential) begin
                        $error("new_potential: expected %0d, got %0d",
                               want.potential, got_v);
                        bad++;
                    end
                    if (got_dv !== want.rate) begin
                        $error("new_potential_rate: expected %0d, got %0d",
                               want.rate, got_dv);
                        bad++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                in_node = s_tdata[0 +: NODE_W];
                in_p    = s_tdata[NODE_W +: Q_W];
                in_v    = s_tdata[NODE_W + Q_W +: Q_W];
                in_dv   = s_tdata[NODE_W + 2*Q_W +: Q_W];
                if (kind_t'(s_tuser) == KIND_LOAD) begin
                    if (in_node < NODES) density_mem[in_node] = in_p;
                end else begin
                    prev = (in_node < NODES) ? density_mem[in_node] : '0;
                    awaited_steps.push_back(predict_step(in_node, in_p, in_v, in_dv, prev));
                    if (in_node < NODES) density_mem[in_node] = in_p;
                end
            end
        end
        mismatch_count  <= bad;
        results_pending <= awaited_steps.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the dendritic step unit bench: clock, reset, register programming,
// step/load stimulus and the verdict. Depends on dso_pkg, dso_step_checker and dendritic_second_order_step_unit.
`timescale 1ns / 1ps

module testbench;
    import dso_pkg::*;

    localparam int NODES   = 1024;
    localparam int LATENCY = 16;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatch_count;
    int                     results_pending;

    bit seeded [NODES];  // density written since reset
    bit calm;            // no idling on either side
    int gap_pct;         // chance of a sender gap before an item

    dendritic_second_order_step_unit #(.NODES(NODES)) dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_we, .cfg_index, .cfg_data
    );

    dso_step_checker #(.NODES(NODES)) step_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_we, .cfg_index, .cfg_data,
        .mismatch_count, .results_pending
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("[dendritic_second_order_step_unit] ERROR");
        $finish;
    end

    // result side: random stall bursts until the final phase
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    task automatic send_item(kind_t kind, logic [NODE_W-1:0] node, logic [31:0] p,
                             logic [31:0] v, logic [31:0] dv);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[0 +: NODE_W]            = node;
        word[NODE_W +: Q_W]          = p;
        word[NODE_W + Q_W +: Q_W]    = v;
        word[NODE_W + 2*Q_W +: Q_W]  = dv;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_LOAD) seeded[node] = 1'b1;
    endtask

    // hold the sender until every step result is back and loads have settled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic program_regs(logic [31:0] alpha, logic [31:0] beta,
                                logic [31:0] fade_a, logic [31:0] fade_b,
                                logic [31:0] inv_dt, logic [31:0] inv_gap,
                                logic [31:0] inv_sum);
        logic [31:0] vals [7];
        reg_index_t  order [7];
        vals  = '{alpha, beta, fade_a, fade_b, inv_dt, inv_gap, inv_sum};
        order = '{REG_RATE_ALPHA, REG_RATE_BETA, REG_DECAY_ALPHA, REG_DECAY_BETA,
                  REG_INVERSE_STEP, REG_INVERSE_RATE_GAP, REG_RATE_SUM_FACTOR};
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 2097152) - 1048576;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            3: return $urandom_range(0, 33554432) - 16777216;
            default: return ($urandom_range(0, 64) - 32) << 16;
        endcase
    endfunction

    // mostly a small hot set of nodes so steps chain on stored densities
    function automatic logic [NODE_W-1:0] pick_node();
        case ($urandom_range(0, 9))
            7, 8:    return NODE_W'($urandom_range(0, NODES - 1));
            9:       return NODE_W'(NODES - 1 - $urandom_range(0, 7));
            default: return NODE_W'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic run_phase(int count);
        logic [NODE_W-1:0] node;
        kind_t             kind;
        for (int i = 0; i < count; i++) begin
            node = pick_node();
            // never step a node whose density was never written
            if (!seeded[node] || $urandom_range(0, 4) == 0) kind = KIND_LOAD;
            else kind = KIND_STEP;
            send_item(kind, node, rand_q(), rand_q(), rand_q());
        end
    endtask

    initial begin
        calm    = 1'b0;
        gap_pct = 30;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= KIND_STEP;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_RATE_ALPHA;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset registers (equal rates), extreme fields, consecutive
        // steps on one node and a step following a load of the same node
        send_item(KIND_LOAD, 10'd0,    32'h7FFF_FFFF, 32'h0, 32'h0);
        send_item(KIND_LOAD, 10'd1023, 32'h8000_0000, 32'h0, 32'h0);
        send_item(KIND_LOAD, 10'd341,  32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_LOAD, 10'd682,  32'hFFFF_0000, 32'h0, 32'h0);
        send_item(KIND_STEP, 10'd0,    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(KIND_STEP, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(KIND_STEP, 10'd341,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_STEP, 10'd341,  32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(KIND_LOAD, 10'd682,  32'h0001_0000, 32'h0, 32'h0);
        send_item(KIND_STEP, 10'd682,  32'h0000_8000, 32'h0001_8000, 32'hFFFF_8000);
        send_item(KIND_STEP, 10'd682,  32'hFFFF_7FFF, 32'h0000_7FFF, 32'h0000_8000);
        send_item(KIND_STEP, 10'd1023, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(KIND_STEP, 10'd0,    32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F);
        send_item(KIND_LOAD, 10'd0,    32'hA5A5_A5A5, 32'h0, 32'h0);
        send_item(KIND_STEP, 10'd0,    32'h5A5A_5A5A, 32'hF0F0_F0F0, 32'h3C3C_3C3C);
        drain();

        // alpha 2, beta 0.5, dt 0.1
        gap_pct = 10;
        program_regs(32'd131072, 32'd32768, 32'd53656, 32'd62340,
                     32'd655360, 32'd43691, 32'd163840);
        run_phase(295);
        drain();

        // all registers at zero
        gap_pct = 50;
        program_regs('0, '0, '0, '0, '0, '0, '0);
        run_phase(295);
        drain();

        // every bit set; only the register widths survive, gap at its minimum
        gap_pct = 20;
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        run_phase(295);
        drain();

        gap_pct = 30;
        program_regs($urandom, $urandom, $urandom_range(0, 65536), $urandom_range(0, 65536),
                     $urandom, $urandom, $urandom);
        run_phase(295);
        drain();

        // alpha 0.5, beta 3, dt 0.05: negative gap; no idling from here on
        calm = 1'b1;
        program_regs(32'd32768, 32'd196608, 32'd63918, 32'd56408,
                     32'd1310720, 32'hFFFF_998A, 32'd152917);
        run_phase(295);
        drain();

        if (mismatch_count == 0 && results_pending == 0) begin
            $display("[dendritic_second_order_step_unit] OK");
        end else begin
            $display("[dendritic_second_order_step_unit] ERROR");
        end
        $finish;
    end

endmodule
